// ===== sv/pcrb_pkg.sv =====
`timescale 1ns / 1ps
package pcrb_pkg;
  localparam int unsigned PcrCountDefault = 24;
  localparam int unsigned WordsPerPcr = 4;

  localparam logic [1:0] KIND_STARTUP = 2'd0;
  localparam logic [1:0] KIND_EXTEND  = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NOT_STARTED = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX   = 2'd2;

  localparam int unsigned FillLo = 17;
  localparam int unsigned FillHi = 22;

  // datapath commands from the controller
  typedef struct packed {
    logic       stage_wr;     // store digest word in staging
    logic       mem_rd;       // pcr memory read flag; never driven, the ram reads every cycle
    logic       load_blk1;    // load old pcr word and staged digest word into schedule
    logic       init_hash;    // load initial hash values
    logic       round;        // perform one compression round
    logic       finish_blk;   // add working vars into hash state
    logic       load_pad;     // load padding block
    logic       mem_wr_hash;  // write hash word back
    logic       mem_wr_fill;  // write startup fill word
    logic [1:0] wsel;         // word selector
  } pcrb_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    init_h = h[i];
  endfunction
endpackage

// ===== sv/pcr_bank_sha256_extend_top.sv =====
`timescale 1ns / 1ps
// pcr bank of PcrCount sha-256 registers, each four 64-bit big-endian words held in
// one ram. kind 0 rewrites every word (one ram write a cycle) and answers with one
// item. extend words 0..2 are staged with no result; word 3 fetches the old register,
// runs two 64-round compressions on one round unit (one round per cycle), then writes
// the four hash words back. a read gives four items, one per word through the ram read
// port. errors give one item. the output register holds a result while the next input
// waits; ready is low until the last result of the current item is taken. the bank has
// no reset clearing pass: it answers "not started" until the first startup clear fills it.
module pcr_bank_sha256_extend_top #(
  parameter int unsigned PcrCount = pcrb_pkg::PcrCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  pcr_index_i,
  input  logic [7:0]  locality_i,
  input  logic [63:0] digest_word_i,
  input  logic [1:0]  digest_word_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] data_word_o,
  output logic [1:0]  word_number_o,
  output logic        last_word_o,
  output logic [31:0] update_count_o
);
  import pcrb_pkg::*;
  localparam int unsigned AW = $clog2(4*PcrCount);

  pcrb_cmd_t   cmd;
  logic [AW-1:0] addr, fill_addr;
  logic [63:0] fill_data, rd_word;
  logic [5:0]  rnd;

  // sequencer: handshakes, status checks, counters
  pcrb_ctrl #(.PcrCount(PcrCount)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .pcr_index_i, .locality_i,
    .digest_word_number_i, .out_valid_o, .out_ready_i, .status_o, .data_word_o,
    .word_number_o, .last_word_o, .update_count_o,
    .cmd_o(cmd), .addr_o(addr), .fill_addr_o(fill_addr), .fill_data_o(fill_data),
    .round_o(rnd), .rd_word_i(rd_word)
  );

  // pcr ram, staging words and sha-256 round unit
  pcrb_datapath #(.PcrCount(PcrCount)) u_dp (
    .clk_i, .cmd_i(cmd), .addr_i(addr), .fill_addr_i(fill_addr), .fill_data_i(fill_data),
    .digest_word_i, .round_i(rnd), .rd_word_o(rd_word)
  );
endmodule

// ===== sv/pcrb_ram.sv =====
`timescale 1ns / 1ps
module pcrb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/pcrb_datapath.sv =====
`timescale 1ns / 1ps
module pcrb_datapath #(
  parameter int unsigned PcrCount = pcrb_pkg::PcrCountDefault
) (
  input  logic                                 clk_i,
  input  pcrb_pkg::pcrb_cmd_t                  cmd_i,
  input  logic [$clog2(4*PcrCount)-1:0]        addr_i,
  input  logic [$clog2(4*PcrCount)-1:0]        fill_addr_i,
  input  logic [63:0]                          fill_data_i,
  input  logic [63:0]                          digest_word_i,
  input  logic [5:0]                           round_i,
  output logic [63:0]                          rd_word_o
);
  import pcrb_pkg::*;
  localparam int unsigned AW = $clog2(4*PcrCount);

  logic [63:0] stage_q [4];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [63:0] rdata;
  logic        we;
  logic [AW-1:0] waddr;
  logic [63:0] wdata;

  assign we    = cmd_i.mem_wr_hash | cmd_i.mem_wr_fill;
  assign waddr = cmd_i.mem_wr_fill ? fill_addr_i : addr_i;
  assign wdata = cmd_i.mem_wr_fill ? fill_data_i
               : {h_q[{cmd_i.wsel, 1'b0}], h_q[{cmd_i.wsel, 1'b1}]};
  assign rd_word_o = rdata;

  pcrb_ram #(.Width(64), .Depth(4*PcrCount)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(addr_i), .rdata_o(rdata)
  );

  // schedule word and round
  logic [31:0] wt, s0w, s1w, w2, w15, s1, ch, t1, s0, maj, t2;
  always_comb begin
    w2  = w_q[14];
    w15 = w_q[1];
    s0w = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1w = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wt  = (round_i < 6'd16) ? w_q[0] : (s1w + w_q[9] + s0w + w_q[0]);
    s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1 + ch + round_k(round_i) + wt;
    s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_wr) stage_q[cmd_i.wsel] <= digest_word_i;
    if (cmd_i.load_blk1) begin
      w_q[{1'b0, cmd_i.wsel, 1'b0}] <= rdata[63:32];
      w_q[{1'b0, cmd_i.wsel, 1'b1}] <= rdata[31:0];
      w_q[{1'b1, cmd_i.wsel, 1'b0}] <= stage_q[cmd_i.wsel][63:32];
      w_q[{1'b1, cmd_i.wsel, 1'b1}] <= stage_q[cmd_i.wsel][31:0];
    end
    if (cmd_i.init_hash) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_h(3'(i));
        v_q[i] <= init_h(3'(i));
      end
    end
    if (cmd_i.round) begin
      // schedule window rotates one word each round
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.finish_blk) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] + v_q[i];
        v_q[i] <= h_q[i] + v_q[i];
      end
    end
    if (cmd_i.load_pad) begin
      w_q[0]  <= 32'h8000_0000;
      for (int i = 1; i < 15; i++) w_q[i] <= '0;
      w_q[15] <= 32'd512;
    end
  end
endmodule

// ===== sv/pcrb_ctrl.sv =====
`timescale 1ns / 1ps
module pcrb_ctrl #(
  parameter int unsigned PcrCount = pcrb_pkg::PcrCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [4:0]                    pcr_index_i,
  input  logic [7:0]                    locality_i,
  input  logic [1:0]                    digest_word_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [63:0]                   data_word_o,
  output logic [1:0]                    word_number_o,
  output logic                          last_word_o,
  output logic [31:0]                   update_count_o,
  output pcrb_pkg::pcrb_cmd_t           cmd_o,
  output logic [$clog2(4*PcrCount)-1:0] addr_o,
  output logic [$clog2(4*PcrCount)-1:0] fill_addr_o,
  output logic [63:0]                   fill_data_o,
  output logic [5:0]                    round_o,
  input  logic [63:0]                   rd_word_i
);
  import pcrb_pkg::*;
  localparam int unsigned AW = $clog2(4*PcrCount);
  localparam logic [AW:0] Total = (AW+1)'(4*PcrCount);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_RND1  = 4'd3;
  localparam logic [3:0] S_FIN1  = 4'd4;
  localparam logic [3:0] S_RND2  = 4'd5;
  localparam logic [3:0] S_FIN2  = 4'd6;
  localparam logic [3:0] S_WB    = 4'd7;
  localparam logic [3:0] S_RDREQ = 4'd8;
  localparam logic [3:0] S_RDOUT = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic [5:0]    rnd_q, rnd_d;
  logic [4:0]    idx_q, idx_d;
  logic [7:0]    loc_q, loc_d;
  logic          started_q, started_d;
  logic [31:0]   ucnt_q, ucnt_d;
  logic          ov_q, ov_d;
  logic [1:0]    st_q, st_d;
  logic [63:0]   dw_q, dw_d;
  logic [1:0]    wn_q, wn_d;
  logic          lw_q, lw_d;
  logic          in_acc, out_acc;
  logic [1:0]    err;
  logic [4:0]    fill_pcr;

  assign in_acc = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) & ~ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign data_word_o = dw_q;
  assign word_number_o = wn_q;
  assign last_word_o = lw_q;
  assign update_count_o = ucnt_q;
  assign round_o = rnd_q;
  assign fill_addr_o = cnt_q[AW-1:0];
  assign fill_pcr = 5'(cnt_q >> 2);
  // locality byte lands in the last word of register 0
  assign fill_data_o = (cnt_q == (AW+1)'(3)) ? {56'd0, loc_q}
                     : ((fill_pcr >= 5'(FillLo) && fill_pcr <= 5'(FillHi)) ? '1 : '0);

  always_comb begin
    err = STATUS_OK;
    if (!started_q) err = STATUS_NOT_STARTED;
    else if ({1'b0, pcr_index_i} >= 6'(PcrCount)) err = STATUS_BAD_INDEX;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rnd_d = rnd_q; idx_d = idx_q; loc_d = loc_q;
    started_d = started_q; ucnt_d = ucnt_q; ov_d = ov_q & ~out_acc;
    st_d = st_q; dw_d = dw_q; wn_d = wn_q; lw_d = lw_q;
    cmd_o = '0;
    cmd_o.wsel = cnt_q[1:0];
    addr_o = AW'({idx_q, 2'b00}) + AW'(cnt_q[1:0]);
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d = pcr_index_i; loc_d = locality_i; cnt_d = '0;
          st_d = err; dw_d = '0; wn_d = '0; lw_d = 1'b1;
          case (kind_i)
            KIND_STARTUP: state_d = S_FILL;
            KIND_EXTEND: begin
              cmd_o.stage_wr = 1'b1;
              cmd_o.wsel = digest_word_number_i;
              if (digest_word_number_i == 2'd3) begin
                if (err != STATUS_OK) ov_d = 1'b1;
                else state_d = S_LOAD;
              end
            end
            KIND_READ: begin
              if (err != STATUS_OK) ov_d = 1'b1;
              else state_d = S_RDREQ;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cmd_o.mem_wr_fill = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == Total - 1'b1) begin
          ucnt_d = '0; started_d = 1'b1; st_d = STATUS_OK; ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        // cnt 0..3 issues reads, 1..4 loads returned words
        cmd_o.wsel = 2'(cnt_q - 1'b1);
        cmd_o.load_blk1 = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(4)) begin
          cmd_o.init_hash = 1'b1; rnd_d = '0; state_d = S_RND1;
        end
      end
      S_RND1: begin
        cmd_o.round = 1'b1; rnd_d = rnd_q + 1'b1;
        if (rnd_q == 6'd63) state_d = S_FIN1;
      end
      S_FIN1: begin
        cmd_o.finish_blk = 1'b1; cmd_o.load_pad = 1'b1; state_d = S_RND2;
      end
      S_RND2: begin
        cmd_o.round = 1'b1; rnd_d = rnd_q + 1'b1;
        if (rnd_q == 6'd63) state_d = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.finish_blk = 1'b1; cnt_d = '0; state_d = S_WB;
      end
      S_WB: begin
        cmd_o.mem_wr_hash = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          ucnt_d = ucnt_q + 1'b1; st_d = STATUS_OK; ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_RDREQ: begin
        state_d = S_RDOUT;
      end
      S_RDOUT: begin
        st_d = STATUS_OK; dw_d = rd_word_i; wn_d = cnt_q[1:0];
        lw_d = (cnt_q[1:0] == 2'd3); ov_d = 1'b1; state_d = S_RESP;
      end
      S_RESP: begin
        if (out_acc) begin
          if (lw_q) state_d = S_IDLE;
          else begin
            cnt_d = cnt_q + 1'b1; state_d = S_RDREQ;
            addr_o = AW'({idx_q, 2'b00}) + AW'(cnt_d[1:0]);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rnd_q <= '0; started_q <= 1'b0;
      ucnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rnd_q <= rnd_d; started_q <= started_d;
      ucnt_q <= ucnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; loc_q <= loc_d; st_q <= st_d; dw_q <= dw_d; wn_q <= wn_d; lw_q <= lw_d;
  end
endmodule

// ===== sv/pcrb_checker.sv =====
`timescale 1ns / 1ps
module pcrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] data_word_o,
  input logic [1:0]  word_number_o,
  input logic        last_word_o
);
  import pcrb_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_word_o))
    else $error("result changed while stalled");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> last_word_o && data_word_o == '0)
    else $error("error item not single");
  a_wn_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_number_o != 2'd0 |-> (last_word_o == (word_number_o == 2'd3)))
    else $error("last flag wrong");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken with result pending");
endmodule

bind pcr_bank_sha256_extend_top pcrb_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .data_word_o, .word_number_o, .last_word_o
);
